>>> rtl/core/mcr_pkg.sv
// Shared types and constants for the midpoint circle rasterizer.
// No dependencies; every other file of the block uses this package.
package mcr_pkg;

    localparam int COORD_WIDTH_DEF = 16;

    localparam int CENTER_W = 15;
    localparam int RADIUS_W = 14;
    localparam int COLOUR_W = 32;
    localparam int POS_X_W  = 16;
    localparam int POS_Y_W  = 15;
    localparam int STEP_W   = 17;
    localparam int ERR_W    = 18;
    localparam int CALC_W   = 19;
    localparam int PT_IDX_W = 3;

    typedef enum logic {
        OP_START   = 1'b0,
        OP_ADVANCE = 1'b1
    } t_op;

    localparam logic [PT_IDX_W-1:0] PT_LAST = 3'd7;

    // One step's worth of work for the point emitter.
    typedef struct packed {
        logic [CENTER_W-1:0] cx;
        logic [CENTER_W-1:0] cy;
        logic [POS_X_W-1:0]  x;
        logic [POS_Y_W-1:0]  y;
        logic [COLOUR_W-1:0] colour;
        logic                done;
    } t_job;

    typedef struct packed {
        logic push;
        t_job job;
    } t_q_wr;

endpackage

>>> rtl/core/mcr_front.sv
// Front end: accepts start and advance items, holds the circle state and
// performs the midpoint step update. Depends on mcr_pkg.
module mcr_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic                            i_op,
    input  logic [mcr_pkg::CENTER_W-1:0]    i_center_x,
    input  logic [mcr_pkg::CENTER_W-1:0]    i_center_y,
    input  logic [mcr_pkg::RADIUS_W-1:0]    i_radius,
    input  logic [mcr_pkg::COLOUR_W-1:0]    i_colour,
    input  logic                            i_q_full,
    output mcr_pkg::t_q_wr                  o_q_wr
);

    logic                           r_active;
    logic [mcr_pkg::CENTER_W-1:0]   r_cx;
    logic [mcr_pkg::CENTER_W-1:0]   r_cy;
    logic [mcr_pkg::RADIUS_W-1:0]   r_r;
    logic [mcr_pkg::COLOUR_W-1:0]   r_colour;
    logic signed [mcr_pkg::POS_X_W-1:0] r_x;
    logic [mcr_pkg::POS_Y_W-1:0]    r_y;
    logic [mcr_pkg::STEP_W-1:0]     r_dx;
    logic [mcr_pkg::STEP_W-1:0]     r_dy;
    logic signed [mcr_pkg::ERR_W-1:0] r_err;

    logic                           start;
    logic                           accept;
    logic                           run;
    logic                           c_active;
    logic [mcr_pkg::CENTER_W-1:0]   c_cx;
    logic [mcr_pkg::CENTER_W-1:0]   c_cy;
    logic [mcr_pkg::RADIUS_W-1:0]   c_r;
    logic [mcr_pkg::COLOUR_W-1:0]   c_colour;
    logic signed [mcr_pkg::POS_X_W-1:0] c_x;
    logic [mcr_pkg::POS_Y_W-1:0]    c_y;
    logic [mcr_pkg::STEP_W-1:0]     c_dx;
    logic [mcr_pkg::STEP_W-1:0]     c_dy;
    logic signed [mcr_pkg::ERR_W-1:0] c_err;
    logic signed [mcr_pkg::CALC_W-1:0] two_r;
    logic signed [mcr_pkg::CALC_W-1:0] e_mid;
    logic signed [mcr_pkg::CALC_W-1:0] e_end;
    logic signed [mcr_pkg::POS_X_W-1:0] n_x;
    logic [mcr_pkg::POS_Y_W-1:0]    n_y;
    logic [mcr_pkg::STEP_W-1:0]     n_dx;
    logic [mcr_pkg::STEP_W-1:0]     n_dy;
    logic                           done;

    assign start   = (i_op == mcr_pkg::OP_START);
    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;

    // A start item replaces the held state before the first step is taken.
    always_comb begin
        c_cx     = start ? i_center_x : r_cx;
        c_cy     = start ? i_center_y : r_cy;
        c_r      = start ? i_radius   : r_r;
        c_colour = start ? i_colour   : r_colour;
        c_x      = start ? $signed({2'b00, i_radius}) - 16'sd1 : r_x;
        c_y      = start ? '0 : r_y;
        c_dx     = start ? mcr_pkg::STEP_W'(1) : r_dx;
        c_dy     = start ? mcr_pkg::STEP_W'(1) : r_dy;
        two_r    = $signed({4'b0000, c_r, 1'b0});
        c_err    = start ? mcr_pkg::ERR_W'(19'sd1 - two_r) : r_err;
        c_active = start ? (i_radius != '0) : r_active;
        run      = c_active && !(c_x < $signed({1'b0, c_y}));
    end

    always_comb begin
        n_x   = c_x;
        n_y   = c_y;
        n_dx  = c_dx;
        n_dy  = c_dy;
        e_mid = mcr_pkg::CALC_W'(c_err);
        if (c_err <= 0) begin
            n_y   = c_y + 1'b1;
            e_mid = e_mid + $signed({2'b00, c_dy});
            n_dy  = c_dy + 2'd2;
        end
        e_end = e_mid;
        if (e_mid > 0) begin
            n_x   = c_x - 16'sd1;
            n_dx  = c_dx + 2'd2;
            e_end = e_mid + $signed({2'b00, n_dx}) - two_r;
        end
        done = n_x < $signed({1'b0, n_y});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_cx     <= '0;
            r_cy     <= '0;
            r_r      <= '0;
            r_colour <= '0;
            r_x      <= '0;
            r_y      <= '0;
            r_dx     <= mcr_pkg::STEP_W'(1);
            r_dy     <= mcr_pkg::STEP_W'(1);
            r_err    <= '0;
        end else if (accept) begin
            r_cx     <= c_cx;
            r_cy     <= c_cy;
            r_r      <= c_r;
            r_colour <= c_colour;
            r_active <= run && !done;
            if (run) begin
                r_x   <= n_x;
                r_y   <= n_y;
                r_dx  <= n_dx;
                r_dy  <= n_dy;
                r_err <= mcr_pkg::ERR_W'(e_end);
            end else begin
                r_x   <= c_x;
                r_y   <= c_y;
                r_dx  <= c_dx;
                r_dy  <= c_dy;
                r_err <= c_err;
            end
        end
    end

    // The points of a step use the position from before the update.
    always_comb begin
        o_q_wr.push       = accept && run;
        o_q_wr.job.cx     = c_cx;
        o_q_wr.job.cy     = c_cy;
        o_q_wr.job.x      = c_x;
        o_q_wr.job.y      = c_y;
        o_q_wr.job.colour = c_colour;
        o_q_wr.job.done   = done;
    end

endmodule

>>> rtl/core/mcr_queue.sv
// Two-entry step queue between the front end and the point emitter.
// Depends on mcr_pkg.
module mcr_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mcr_pkg::t_q_wr    i_q_wr,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_nonempty,
    output mcr_pkg::t_job     o_job
);

    mcr_pkg::t_job r_mem [2];
    logic          r_wr;
    logic          r_rd;
    logic [1:0]    r_count;

    assign o_full     = (r_count == 2'd2);
    assign o_nonempty = (r_count != 2'd0);
    assign o_job      = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_q_wr.push) begin
            r_mem[r_wr] <= i_q_wr.job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_q_wr.push) begin
                r_wr <= !r_wr;
            end
            if (i_pop) begin
                r_rd <= !r_rd;
            end
            r_count <= r_count + {1'b0, i_q_wr.push} - {1'b0, i_pop};
        end
    end

endmodule

>>> rtl/core/mcr_back.sv
// Point emitter: turns one queued step into eight mirrored points, one per
// cycle unless the output stalls, via a registered output stage. Depends on mcr_pkg.
module mcr_back #(
    parameter int COORD_WIDTH = mcr_pkg::COORD_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_q_nonempty,
    input  mcr_pkg::t_job                   i_job,
    output logic                            o_pop,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic signed [COORD_WIDTH-1:0]   o_point_x,
    output logic signed [COORD_WIDTH-1:0]   o_point_y,
    output logic [mcr_pkg::COLOUR_W-1:0]    o_point_colour,
    output logic                            o_step_last,
    output logic                            o_circle_done
);

    mcr_pkg::t_job                  r_job;
    logic                           r_busy;
    logic [mcr_pkg::PT_IDX_W-1:0]   r_idx;
    logic                           r_out_valid;

    logic                           emit;
    logic                           last;
    logic                           swap;
    logic                           neg_x;
    logic                           neg_y;
    logic signed [COORD_WIDTH-1:0]  cx;
    logic signed [COORD_WIDTH-1:0]  cy;
    logic signed [COORD_WIDTH-1:0]  ofs_x;
    logic signed [COORD_WIDTH-1:0]  ofs_y;
    logic signed [COORD_WIDTH-1:0]  ext_x;
    logic signed [COORD_WIDTH-1:0]  ext_y;
    logic signed [COORD_WIDTH-1:0]  n_px;
    logic signed [COORD_WIDTH-1:0]  n_py;

    assign emit  = r_busy && (!r_out_valid || i_ready);
    assign last  = (r_idx == mcr_pkg::PT_LAST);
    assign o_pop = i_q_nonempty && (!r_busy || (emit && last));

    // Octant order: (+x,+y) (+y,+x) (-y,+x) (-x,+y) (-x,-y) (-y,-x) (+y,-x) (+x,-y).
    always_comb begin
        case (r_idx)
            3'd0:    {swap, neg_x, neg_y} = 3'b000;
            3'd1:    {swap, neg_x, neg_y} = 3'b100;
            3'd2:    {swap, neg_x, neg_y} = 3'b110;
            3'd3:    {swap, neg_x, neg_y} = 3'b010;
            3'd4:    {swap, neg_x, neg_y} = 3'b011;
            3'd5:    {swap, neg_x, neg_y} = 3'b111;
            3'd6:    {swap, neg_x, neg_y} = 3'b101;
            default: {swap, neg_x, neg_y} = 3'b001;
        endcase
    end

    always_comb begin
        cx    = COORD_WIDTH'($signed(r_job.cx));
        cy    = COORD_WIDTH'($signed(r_job.cy));
        ext_x = COORD_WIDTH'($signed(r_job.x));
        ext_y = COORD_WIDTH'($signed({1'b0, r_job.y}));
        ofs_x = swap ? ext_y : ext_x;
        ofs_y = swap ? ext_x : ext_y;
        n_px  = neg_x ? cx - ofs_x : cx + ofs_x;
        n_py  = neg_y ? cy - ofs_y : cy + ofs_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else if (emit && last) begin
                r_busy <= 1'b0;
            end else if (emit) begin
                r_idx <= r_idx + 1'b1;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
        end
        if (emit) begin
            o_point_x      <= n_px;
            o_point_y      <= n_py;
            o_point_colour <= r_job.colour;
            o_step_last    <= last;
            o_circle_done  <= last && r_job.done;
        end
    end

    assign o_valid = r_out_valid;

endmodule

>>> rtl/core/midpoint_circle_rasterizer.sv
// The first point of a step passes the step queue, the emitter's job register and the
// output register. Throughput: one point per cycle unless i_ready stalls it, set by the
// single point output; the two-entry step queue lets items be taken while points drain.
// Start items with radius 0 and advances after completion draw no points.
// Reset (i_rst_n low, synchronous) empties the queue and output and clears the circle.
module midpoint_circle_rasterizer #(
    parameter int COORD_WIDTH = mcr_pkg::COORD_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic                            i_op,
    input  logic [mcr_pkg::CENTER_W-1:0]    i_center_x,
    input  logic [mcr_pkg::CENTER_W-1:0]    i_center_y,
    input  logic [mcr_pkg::RADIUS_W-1:0]    i_radius,
    input  logic [mcr_pkg::COLOUR_W-1:0]    i_colour,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic signed [COORD_WIDTH-1:0]   o_point_x,
    output logic signed [COORD_WIDTH-1:0]   o_point_y,
    output logic [mcr_pkg::COLOUR_W-1:0]    o_point_colour,
    output logic                            o_step_last,
    output logic                            o_circle_done
);

    mcr_pkg::t_q_wr q_wr;
    mcr_pkg::t_job  q_job;
    logic           q_full;
    logic           q_nonempty;
    logic           q_pop;

    mcr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_op       (i_op),
        .i_center_x (i_center_x),
        .i_center_y (i_center_y),
        .i_radius   (i_radius),
        .i_colour   (i_colour),
        .i_q_full   (q_full),
        .o_q_wr     (q_wr)
    );

    mcr_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_wr     (q_wr),
        .i_pop      (q_pop),
        .o_full     (q_full),
        .o_nonempty (q_nonempty),
        .o_job      (q_job)
    );

    mcr_back #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_nonempty   (q_nonempty),
        .i_job          (q_job),
        .o_pop          (q_pop),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_point_x      (o_point_x),
        .o_point_y      (o_point_y),
        .o_point_colour (o_point_colour),
        .o_step_last    (o_step_last),
        .o_circle_done  (o_circle_done)
    );

endmodule

>>> rtl/core/mcr_checker.sv
// Port-level checks for the midpoint circle rasterizer, bound to the top level.
// Depends on mcr_pkg and midpoint_circle_rasterizer.
module mcr_checker #(
    parameter int COORD_WIDTH = mcr_pkg::COORD_WIDTH_DEF
) (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_valid,
    input logic                           i_ready,
    input logic signed [COORD_WIDTH-1:0]  o_point_x,
    input logic signed [COORD_WIDTH-1:0]  o_point_y,
    input logic [mcr_pkg::COLOUR_W-1:0]   o_point_colour,
    input logic                           o_step_last,
    input logic                           o_circle_done
);

    // A stalled point holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_point_x) && $stable(o_point_y)
            && $stable(o_point_colour) && $stable(o_step_last))
        else $error("output point changed while stalled");

    // The circle only finishes on the eighth point of a step.
    a_done_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_circle_done |-> o_step_last)
        else $error("circle done flagged on a point that is not last");

    // The eight points of a step leave back to back.
    a_step_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_step_last |=> o_valid)
        else $error("gap inside the points of one step");

    // Points within one step share the circle colour.
    a_step_colour: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_step_last |=> $stable(o_point_colour))
        else $error("colour changed within a step");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

endmodule

bind midpoint_circle_rasterizer mcr_checker #(
    .COORD_WIDTH (COORD_WIDTH)
) u_mcr_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_point_x      (o_point_x),
    .o_point_y      (o_point_y),
    .o_point_colour (o_point_colour),
    .o_step_last    (o_step_last),
    .o_circle_done  (o_circle_done)
);

>>> tb/sv/tb_midpoint_circle_rasterizer.sv
`timescale 1ns / 1ps
// Self-checking testbench for the midpoint circle rasterizer.
// It depends on mcr_pkg and the midpoint_circle_rasterizer top level and nothing else.
module tb_midpoint_circle_rasterizer;

    localparam int CW             = mcr_pkg::COORD_WIDTH_DEF;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int STALL_CYCLES   = 300;
    localparam int SETTLE_CYCLES  = 8;

    typedef struct {
        logic signed [CW-1:0]         px;
        logic signed [CW-1:0]         py;
        logic [mcr_pkg::COLOUR_W-1:0] colour;
        logic                         last;
        logic                         done;
    } t_point;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_valid;
    logic                         o_ready;
    logic                         i_op;
    logic [mcr_pkg::CENTER_W-1:0] i_center_x;
    logic [mcr_pkg::CENTER_W-1:0] i_center_y;
    logic [mcr_pkg::RADIUS_W-1:0] i_radius;
    logic [mcr_pkg::COLOUR_W-1:0] i_colour;
    logic                         o_valid;
    logic                         i_ready;
    logic signed [CW-1:0]         o_point_x;
    logic signed [CW-1:0]         o_point_y;
    logic [mcr_pkg::COLOUR_W-1:0] o_point_colour;
    logic                         o_step_last;
    logic                         o_circle_done;

    midpoint_circle_rasterizer #(
        .COORD_WIDTH(CW)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_op           (i_op),
        .i_center_x     (i_center_x),
        .i_center_y     (i_center_y),
        .i_radius       (i_radius),
        .i_colour       (i_colour),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_point_x      (o_point_x),
        .o_point_y      (o_point_y),
        .o_point_colour (o_point_colour),
        .o_step_last    (o_step_last),
        .o_circle_done  (o_circle_done)
    );

    // Circle state as the block should hold it.
    logic                                circ_active;
    logic signed [mcr_pkg::CENTER_W-1:0] hold_cx;
    logic signed [mcr_pkg::CENTER_W-1:0] hold_cy;
    logic [mcr_pkg::RADIUS_W-1:0]        hold_r;
    logic [mcr_pkg::COLOUR_W-1:0]        hold_colour;
    int                                  cur_x;
    int                                  cur_y;
    int                                  inc_dx;
    int                                  inc_dy;
    int                                  err_acc;

    t_point expected_points[$];
    t_point next_pt;
    bit     item_drew;
    int     mismatches = 0;
    int     items_sent;
    int     points_seen = 0;
    int     circles_closed = 0;
    int     tx_idle_pct;
    int     rx_idle_pct;
    logic   rx_hold;
    int     quiet_cycles;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic void push_point(input int px, input int py, input bit last,
                                       input bit done);
        t_point p;
        p.px     = px[CW-1:0];
        p.py     = py[CW-1:0];
        p.colour = hold_colour;
        p.last   = last;
        p.done   = done;
        expected_points.push_back(p);
    endfunction

    // Applies one accepted item to the circle state and queues the points it draws.
    function automatic bit rasterize_item(input mcr_pkg::t_op op,
                                          input logic [mcr_pkg::CENTER_W-1:0] cx,
                                          input logic [mcr_pkg::CENTER_W-1:0] cy,
                                          input logic [mcr_pkg::RADIUS_W-1:0] r,
                                          input logic [mcr_pkg::COLOUR_W-1:0] col);
        int x0;
        int y0;
        int ccx;
        int ccy;
        bit fin;
        if (op == mcr_pkg::OP_START) begin
            hold_cx     = cx;
            hold_cy     = cy;
            hold_r      = r;
            hold_colour = col;
            cur_x       = int'(r) - 1;
            cur_y       = 0;
            inc_dx      = 1;
            inc_dy      = 1;
            err_acc     = 1 - 2 * int'(r);
            circ_active = (int'(r) - 1 >= 0);
        end
        x0 = cur_x;
        y0 = cur_y;
        if (!circ_active || x0 < y0) begin
            circ_active = 1'b0;
            return 1'b0;
        end
        if (err_acc <= 0) begin
            cur_y   = cur_y + 1;
            err_acc = err_acc + inc_dy;
            inc_dy  = inc_dy + 2;
        end
        if (err_acc > 0) begin
            cur_x   = cur_x - 1;
            inc_dx  = inc_dx + 2;
            err_acc = err_acc + inc_dx - 2 * int'(hold_r);
        end
        fin = (cur_x < cur_y);
        if (fin) begin
            circ_active = 1'b0;
        end
        ccx = int'(hold_cx);
        ccy = int'(hold_cy);
        // Points use the position from before the update, one per octant.
        push_point(ccx + x0, ccy + y0, 1'b0, 1'b0);
        push_point(ccx + y0, ccy + x0, 1'b0, 1'b0);
        push_point(ccx - y0, ccy + x0, 1'b0, 1'b0);
        push_point(ccx - x0, ccy + y0, 1'b0, 1'b0);
        push_point(ccx - x0, ccy - y0, 1'b0, 1'b0);
        push_point(ccx - y0, ccy - x0, 1'b0, 1'b0);
        push_point(ccx + y0, ccy - x0, 1'b0, 1'b0);
        push_point(ccx + x0, ccy - y0, 1'b1, fin);
        return 1'b1;
    endfunction

    function automatic void check_field(input string what, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %h got %h", $time, what, want, got);
            mismatches++;
        end
    endfunction

    // Valid is left high after acceptance; the next send or a drain decides
    // in the same time step whether it stays up.
    task automatic send_item(input mcr_pkg::t_op op,
                             input logic [mcr_pkg::CENTER_W-1:0] cx,
                             input logic [mcr_pkg::CENTER_W-1:0] cy,
                             input logic [mcr_pkg::RADIUS_W-1:0] r,
                             input logic [mcr_pkg::COLOUR_W-1:0] col);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_op       <= op;
        i_center_x <= cx;
        i_center_y <= cy;
        i_radius   <= r;
        i_colour   <= col;
        @(posedge i_clk);
        while (!o_ready) begin
            @(posedge i_clk);
        end
        item_drew = rasterize_item(op, cx, cy, r, col);
        items_sent++;
    endtask

    // The fields of an advance item are ignored, so they carry noise.
    task automatic send_advance();
        send_item(mcr_pkg::OP_ADVANCE, mcr_pkg::CENTER_W'($urandom),
                  mcr_pkg::CENTER_W'($urandom), mcr_pkg::RADIUS_W'($urandom), $urandom);
    endtask

    task automatic drain_points();
        i_valid <= 1'b0;
        while (expected_points.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_idling(input int tx_pct, input int rx_pct);
        tx_idle_pct = tx_pct;
        rx_idle_pct <= rx_pct;
    endtask

    task automatic test_directed();
        // Nothing is drawn yet, so an advance and a zero radius draw nothing.
        send_advance();
        send_item(mcr_pkg::OP_START, 15'h3FFF, 15'h4000, 14'd0, 32'hFFFF_FFFF);
        send_advance();
        // Radius one closes in a single step.
        send_item(mcr_pkg::OP_START, 15'h4000, 15'h4000, 14'd1, 32'h0000_0000);
        send_advance();
        // Largest radius at both corners; the second start abandons the first circle.
        send_item(mcr_pkg::OP_START, 15'h3FFF, 15'h3FFF, 14'h3FFF, 32'hFFFF_FFFF);
        repeat (3) send_advance();
        send_item(mcr_pkg::OP_START, 15'h4000, 15'h4000, 14'h3FFF, 32'h8000_0001);
        repeat (2) send_advance();
        // A zero radius start while a circle is active stops it.
        send_item(mcr_pkg::OP_START, 15'h0000, 15'h0000, 14'd5, 32'h1234_5678);
        send_advance();
        send_item(mcr_pkg::OP_START, 15'h0001, 15'h7FFF, 14'd0, 32'h0F0F_0F0F);
        send_advance();
        send_item(mcr_pkg::OP_START, 15'h0000, 15'h0000, 14'd3, 32'hA5A5_5A5A);
        while (circ_active) begin
            send_advance();
        end
        send_advance();
        send_item(mcr_pkg::OP_START, 15'h3FFF, 15'h4000, 14'd2, 32'h5A5A_A5A5);
        while (circ_active) begin
            send_advance();
        end
        drain_points();
    endtask

    task automatic run_random_circles(input int target);
        int drawn;
        int roll;
        int steps;
        int abandon;
        int r;
        drawn = 0;
        while (drawn < target) begin
            roll = $urandom_range(99);
            if (roll < 10) begin
                if ($urandom_range(1) == 1) begin
                    send_advance();
                end else begin
                    send_item(mcr_pkg::OP_START, mcr_pkg::CENTER_W'($urandom),
                              mcr_pkg::CENTER_W'($urandom), 14'd0, $urandom);
                end
                drawn += item_drew;
            end else if (roll < 20) begin
                // Any radius, with at most four advances after the start.
                send_item(mcr_pkg::OP_START, mcr_pkg::CENTER_W'($urandom),
                          mcr_pkg::CENTER_W'($urandom), mcr_pkg::RADIUS_W'($urandom),
                          $urandom);
                drawn += item_drew;
                steps = $urandom_range(4);
                repeat (steps) begin
                    send_advance();
                    drawn += item_drew;
                end
            end else begin
                r = $urandom_range(24, 1);
                send_item(mcr_pkg::OP_START, mcr_pkg::CENTER_W'($urandom),
                          mcr_pkg::CENTER_W'($urandom), r[mcr_pkg::RADIUS_W-1:0],
                          $urandom);
                drawn += item_drew;
                abandon = ($urandom_range(4) == 0) ? $urandom_range(6, 1) : -1;
                steps = 0;
                while (circ_active && steps != abandon) begin
                    send_advance();
                    drawn += item_drew;
                    steps++;
                end
                if ($urandom_range(3) == 0) begin
                    send_advance();
                end
            end
        end
        drain_points();
    endtask

    // The output is held off while starts keep coming, so the input has to stall.
    task automatic test_output_stall();
        int k;
        fork
            begin
                rx_hold <= 1'b1;
                repeat (STALL_CYCLES) @(posedge i_clk);
                rx_hold <= 1'b0;
            end
        join_none
        for (k = 0; k < 6; k++) begin
            send_item(mcr_pkg::OP_START, mcr_pkg::CENTER_W'($urandom),
                      mcr_pkg::CENTER_W'($urandom), 14'd12, $urandom);
            send_advance();
        end
        drain_points();
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n || rx_hold) begin
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            points_seen++;
            if (expected_points.size() == 0) begin
                $display("%0t: point with nothing expected, got x=%h y=%h", $time,
                         o_point_x, o_point_y);
                mismatches++;
            end else begin
                next_pt = expected_points.pop_front();
                check_field("point_x", 32'(next_pt.px), 32'(o_point_x));
                check_field("point_y", 32'(next_pt.py), 32'(o_point_y));
                check_field("point_colour", next_pt.colour, o_point_colour);
                check_field("step_last", 32'(next_pt.last), 32'(o_step_last));
                check_field("circle_done", 32'(next_pt.done), 32'(o_circle_done));
                if (next_pt.done) begin
                    circles_closed++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $time, quiet_cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        circ_active    = 1'b0;
        hold_cx        = '0;
        hold_cy        = '0;
        hold_r         = '0;
        hold_colour    = '0;
        cur_x          = 0;
        cur_y          = 0;
        inc_dx         = 1;
        inc_dy         = 1;
        err_acc        = 0;
        items_sent     = 0;
        tx_idle_pct    = 0;
        rx_idle_pct    <= 0;
        rx_hold        <= 1'b0;
        i_rst_n        <= 1'b0;
        i_valid        <= 1'b0;
        i_op           <= mcr_pkg::OP_START;
        i_center_x     <= '0;
        i_center_y     <= '0;
        i_radius       <= '0;
        i_colour       <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        set_idling(9, 47);
        test_directed();
        run_random_circles(60);
        set_idling(47, 9);
        run_random_circles(60);
        test_output_stall();
        set_idling(0, 0);
        run_random_circles(60);

        $display("Sent %0d items and checked %0d points, %0d circles closed.",
                 items_sent, points_seen, circles_closed);
        $display("Covered corner centres, zero and full radii, restarts and a long output stall.");
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
